>>> src/ptts_pkg.sv
// Package for the periodic task tick scheduler.
// Holds the command codes, the fixed field widths and the parameter defaults.
package ptts_pkg;

  // Fixed widths of the item fields
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned MASK_W  = 8;
  localparam int unsigned WIDE_W  = 32;

  // Parameter defaults
  localparam int unsigned TASK_SLOTS_DEF = 8;
  localparam int unsigned COUNT_BITS_DEF = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_CREATE  = 3'd1,
    CMD_DELETE  = 3'd2,
    CMD_SUSPEND = 3'd3,
    CMD_RESUME  = 3'd4
  } cmd_e;

endpackage

>>> src/periodic_task_tick_scheduler.sv
// Periodic task tick scheduler: create, delete, suspend and resume go from accept through
// the finish state to the result register; a tick first walks all slots, reading and
// writing back one slot per cycle through the slot memory and the shared tick unit.
// One item is taken at a time: no new item is accepted until its result is registered.
// Reset clears all used and running flags at once; period and countdown are written
// by create and need no clearing.
module periodic_task_tick_scheduler
  import ptts_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = TASK_SLOTS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [TIME_W-1:0] period_i,
  input  logic [TIME_W-1:0] first_delay_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [MASK_W-1:0] fired_mask_o,
  output logic              accepted_o
);

  localparam int unsigned IDX_W  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned WORD_W = 2 * COUNT_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_FINISH
  } state_e;

  state_e              state_q;
  logic [TASK_SLOTS-1:0] used_q;
  logic [TASK_SLOTS-1:0] run_q;
  logic [IDX_W-1:0]    rd_idx_q;
  logic                rd_done_q;
  logic [IDX_W-1:0]    wb_idx_q;
  logic                wb_vld_q;
  logic [MASK_W-1:0]   fired_q;
  logic                acc_q;
  logic                out_valid_q;
  logic [MASK_W-1:0]   out_mask_q;
  logic                out_acc_q;

  logic                accept;
  logic                in_table;
  logic [IDX_W-1:0]    slot_idx;
  logic [WIDE_W-1:0]   per_wide;
  logic [WIDE_W-1:0]   delay_wide;
  logic [COUNT_BITS-1:0] per_cut;
  logic [COUNT_BITS-1:0] per_eff;
  logic [COUNT_BITS-1:0] delay_cut;
  logic                create_ok;
  logic                issue;
  logic                wb_live;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [WORD_W-1:0]   ram_rdata;
  logic [COUNT_BITS-1:0] rd_period;
  logic [COUNT_BITS-1:0] rd_count;
  logic                alu_fire;
  logic [COUNT_BITS-1:0] alu_next;

  // Decode the incoming item
  always_comb begin
    accept     = in_valid_i && in_ready_o;
    in_table   = (WIDE_W'(slot_i) < WIDE_W'(TASK_SLOTS));
    per_wide   = WIDE_W'(slot_i);
    slot_idx   = per_wide[IDX_W-1:0];
    per_wide   = WIDE_W'(period_i);
    delay_wide = WIDE_W'(first_delay_i);
    per_cut    = per_wide[COUNT_BITS-1:0];
    delay_cut  = delay_wide[COUNT_BITS-1:0];
    per_eff    = (per_cut == '0) ? COUNT_BITS'(1) : per_cut;
    create_ok  = in_table && !used_q[slot_idx];
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign issue      = (state_q == ST_TICK) && !rd_done_q;
  assign wb_live    = wb_vld_q && used_q[wb_idx_q] && run_q[wb_idx_q];
  assign rd_period  = ram_rdata[WORD_W-1:COUNT_BITS];
  assign rd_count   = ram_rdata[COUNT_BITS-1:0];

  // Select the memory write: create on accept, or write back during a tick walk
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wb_idx_q;
    ram_wdata = {rd_period, alu_next};
    if (accept && (cmd_e'(command_i) == CMD_CREATE) && create_ok) begin
      ram_we    = 1'b1;
      ram_waddr = slot_idx;
      ram_wdata = {per_eff, delay_cut};
    end else if (wb_live) begin
      ram_we = 1'b1;
    end
  end

  ptts_slot_ram #(
    .DEPTH  (TASK_SLOTS),
    .WIDTH  (WORD_W),
    .ADDR_W (IDX_W)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  ptts_tick_alu #(
    .COUNT_BITS (COUNT_BITS)
  ) u_tick_alu (
    .period_i (rd_period),
    .count_i  (rd_count),
    .fire_o   (alu_fire),
    .next_o   (alu_next)
  );

  // Sequencer, slot flags, walk counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      run_q       <= '0;
      rd_idx_q    <= '0;
      rd_done_q   <= 1'b0;
      wb_idx_q    <= '0;
      wb_vld_q    <= 1'b0;
      fired_q     <= '0;
      acc_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_mask_q  <= '0;
      out_acc_q   <= 1'b0;
    end else begin
      // Drop the result once taken
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            fired_q   <= '0;
            acc_q     <= 1'b1;
            rd_idx_q  <= '0;
            rd_done_q <= 1'b0;
            wb_vld_q  <= 1'b0;
            state_q   <= ST_FINISH;
            unique case (cmd_e'(command_i))
              CMD_TICK: begin
                state_q <= ST_TICK;
              end
              CMD_CREATE: begin
                if (create_ok) begin
                  used_q[slot_idx] <= 1'b1;
                  run_q[slot_idx]  <= 1'b1;
                end else begin
                  acc_q <= 1'b0;
                end
              end
              CMD_DELETE: begin
                if (in_table) begin
                  used_q[slot_idx] <= 1'b0;
                end
              end
              CMD_SUSPEND: begin
                if (in_table) begin
                  run_q[slot_idx] <= 1'b0;
                end
              end
              CMD_RESUME: begin
                if (in_table) begin
                  run_q[slot_idx] <= 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end

        ST_TICK: begin
          // Advance the read pointer
          wb_vld_q <= issue;
          wb_idx_q <= rd_idx_q;
          if (issue) begin
            if (rd_idx_q == LAST_IDX) begin
              rd_done_q <= 1'b1;
            end else begin
              rd_idx_q <= rd_idx_q + IDX_W'(1);
            end
          end
          // Record firings of the slot in write back
          if (wb_live && alu_fire) begin
            for (int b = 0; b < MASK_W; b++) begin
              if (WIDE_W'(wb_idx_q) == WIDE_W'(b)) begin
                fired_q[b] <= 1'b1;
              end
            end
          end
          if (wb_vld_q && (wb_idx_q == LAST_IDX)) begin
            wb_vld_q <= 1'b0;
            state_q  <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          // Hold until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_mask_q  <= fired_q;
            out_acc_q   <= acc_q;
            state_q     <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign fired_mask_o = out_mask_q;
  assign accepted_o   = out_acc_q;

`ifndef SYNTHESIS
  // An accepted item keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready stayed high after an accept");

  // Write back only happens during a tick walk
  a_wb_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_vld_q |-> (state_q == ST_TICK))
    else $error("write back outside a tick walk");

  // A memory write during a tick walk is a write back of a live slot
  a_tick_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && (state_q == ST_TICK)) |-> wb_live)
    else $error("unexpected memory write during tick walk");

  // A refused create never reports fired slots
  a_refused_no_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !accepted_o) |-> (fired_mask_o == '0))
    else $error("refused item carries a fired mask");
`endif

endmodule

>>> src/ptts_slot_ram.sv
// Slot table memory: one {period, countdown} word per task slot.
// One write port and one read port with registered read data; no dependencies.
module ptts_slot_ram #(
  parameter int unsigned DEPTH  = 8,
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = 3
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/ptts_tick_alu.sv
// Shared tick unit: tests one countdown for zero and forms its next value.
// A single decrementer serves both the reload and the count down; no dependencies.
module ptts_tick_alu #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic [COUNT_BITS-1:0] period_i,
  input  logic [COUNT_BITS-1:0] count_i,
  output logic                  fire_o,
  output logic [COUNT_BITS-1:0] next_o
);

  logic [COUNT_BITS-1:0] operand;

  // Fire on zero, then reload with period minus one, else count down
  always_comb begin
    fire_o  = (count_i == '0);
    operand = fire_o ? period_i : count_i;
    next_o  = operand - COUNT_BITS'(1);
  end

endmodule
